### hw/rtl/vdi_pkg.sv
package vdi_pkg;

   localparam int MAX_UNIQUE   = 4096;
   localparam int BUCKET_COUNT = 8192;

   localparam int POS_W     = 32;
   localparam int OUT_IDX_W = 12;
   localparam int IDX_W     = $clog2(MAX_UNIQUE);
   localparam int CNT_W     = $clog2(MAX_UNIQUE + 1);
   localparam int BKT_W     = $clog2(BUCKET_COUNT);
   localparam int KEY_W     = 3 * POS_W;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_UNIQUE);
   localparam logic [BKT_W-1:0] PROBE_LAST = BKT_W'(BUCKET_COUNT - 1);
   localparam logic [CNT_W-1:0] ENTRY_EMPTY = '0;

   typedef struct packed {
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [POS_W-1:0] pos_z;
   } req_word_type;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] vert_idx;
      logic                 is_new;
      logic                 overflow;
   } rsp_word_type;

   // xor fold of the three coordinates onto the bucket address, each at its own offset
   function automatic logic [BKT_W-1:0] bucket_hash(req_word_type key);
      logic [BKT_W-1:0] h;
      h = '0;
      for (int i = 0; i < POS_W; i++) begin
         h[i % BKT_W]       = h[i % BKT_W] ^ key.pos_x[i];
         h[(i + 5) % BKT_W] = h[(i + 5) % BKT_W] ^ key.pos_y[i];
         h[(i + 9) % BKT_W] = h[(i + 9) % BKT_W] ^ key.pos_z[i];
      end
      return h;
   endfunction

endpackage

### hw/rtl/vdi_ram.sv
module vdi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/vertex_dedup_indexer_unit.sv
// Vertex deduplication by linear-probe hashing. One start/busy word carries a vertex position
// as three raw float bit patterns; positions match only on identical bits. The reply is one
// rsp_valid strobe with the stored index, or a new index with is_new, or overflow when the
// unique store (4096 entries) is full. The receiver cannot stall: a result is shown for one
// cycle only. After reset the block sweeps the 8192-entry bucket memory clear, one bucket a
// cycle, and holds busy for the whole sweep. Timing is set by the bucket memory and the
// position memory, both with a registered read: a new position that lands in an empty bucket
// goes from accept through the bucket check back to idle, a hit on the first bucket adds a
// position compare, and every further occupied bucket on the probe chain adds a bucket read, a
// bucket check and a position compare. Busy holds until the reply, so no new position is taken before it.
module vertex_dedup_indexer_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  vdi_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   output vdi_pkg::rsp_word_type rsp_word
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_BRD   = 3'd2;
   localparam logic [2:0] ST_BCHK  = 3'd3;
   localparam logic [2:0] ST_SCHK  = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [vdi_pkg::BKT_W-1:0]    clr_ff, clr_in;
   logic [vdi_pkg::CNT_W-1:0]    count_ff, count_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   vdi_pkg::req_word_type        key_ff, key_in;
   logic [vdi_pkg::BKT_W-1:0]    slot_ff, slot_in;
   logic [vdi_pkg::BKT_W-1:0]    probe_ff, probe_in;
   logic [vdi_pkg::IDX_W-1:0]    idx_ff, idx_in;
   vdi_pkg::rsp_word_type        rsp_word_ff, rsp_word_in;

   logic                         bkt_wr_en;
   logic [vdi_pkg::BKT_W-1:0]    bkt_wr_addr;
   logic [vdi_pkg::CNT_W-1:0]    bkt_wr_data;
   logic [vdi_pkg::BKT_W-1:0]    bkt_rd_addr;
   logic [vdi_pkg::CNT_W-1:0]    bkt_rd_data;

   logic                         sto_wr_en;
   logic [vdi_pkg::IDX_W-1:0]    sto_wr_addr;
   logic [vdi_pkg::KEY_W-1:0]    sto_wr_data;
   logic [vdi_pkg::IDX_W-1:0]    sto_rd_addr;
   logic [vdi_pkg::KEY_W-1:0]    sto_rd_data;

   logic [vdi_pkg::CNT_W-1:0]    entry_idx;

   vdi_ram #(
      .WIDTH (vdi_pkg::CNT_W),
      .DEPTH (vdi_pkg::BUCKET_COUNT)
   ) u_bucket_ram (
      .clock   (clock),
      .wr_en   (bkt_wr_en),
      .wr_addr (bkt_wr_addr),
      .wr_data (bkt_wr_data),
      .rd_addr (bkt_rd_addr),
      .rd_data (bkt_rd_data)
   );

   vdi_ram #(
      .WIDTH (vdi_pkg::KEY_W),
      .DEPTH (vdi_pkg::MAX_UNIQUE)
   ) u_store_ram (
      .clock   (clock),
      .wr_en   (sto_wr_en),
      .wr_addr (sto_wr_addr),
      .wr_data (sto_wr_data),
      .rd_addr (sto_rd_addr),
      .rd_data (sto_rd_data)
   );

   // bucket entries hold index + 1
   assign entry_idx = bkt_rd_data - vdi_pkg::CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      key_in       = key_ff;
      slot_in      = slot_ff;
      probe_in     = probe_ff;
      idx_in       = idx_ff;
      rsp_word_in  = rsp_word_ff;

      bkt_wr_en    = 1'b0;
      bkt_wr_addr  = slot_ff;
      bkt_wr_data  = vdi_pkg::CNT_W'(count_ff + vdi_pkg::CNT_W'(1));
      bkt_rd_addr  = slot_ff;
      sto_wr_en    = 1'b0;
      sto_wr_addr  = vdi_pkg::IDX_W'(count_ff);
      sto_wr_data  = key_ff;
      sto_rd_addr  = vdi_pkg::IDX_W'(entry_idx);

      case (state_ff)
         ST_CLEAR: begin
            bkt_wr_en   = 1'b1;
            bkt_wr_addr = clr_ff;
            bkt_wr_data = vdi_pkg::ENTRY_EMPTY;
            clr_in      = clr_ff + vdi_pkg::BKT_W'(1);
            if (clr_ff == vdi_pkg::PROBE_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            bkt_rd_addr = vdi_pkg::bucket_hash(req_word);
            if (start) begin
               key_in   = req_word;
               slot_in  = vdi_pkg::bucket_hash(req_word);
               probe_in = '0;
               state_in = ST_BCHK;
            end
         end
         ST_BRD: begin
            state_in = ST_BCHK;
         end
         ST_BCHK: begin
            if (bkt_rd_data == vdi_pkg::ENTRY_EMPTY) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (count_ff == vdi_pkg::FULL_COUNT) begin
                  rsp_word_in.vert_idx = '0;
                  rsp_word_in.is_new   = 1'b0;
                  rsp_word_in.overflow = 1'b1;
               end else begin
                  bkt_wr_en            = 1'b1;
                  sto_wr_en            = 1'b1;
                  count_in             = count_ff + vdi_pkg::CNT_W'(1);
                  rsp_word_in.vert_idx = vdi_pkg::OUT_IDX_W'(count_ff);
                  rsp_word_in.is_new   = 1'b1;
                  rsp_word_in.overflow = 1'b0;
               end
            end else begin
               idx_in   = vdi_pkg::IDX_W'(entry_idx);
               state_in = ST_SCHK;
            end
         end
         ST_SCHK: begin
            if (sto_rd_data == vdi_pkg::KEY_W'(key_ff)) begin
               rsp_valid_in         = 1'b1;
               rsp_word_in.vert_idx = vdi_pkg::OUT_IDX_W'(idx_ff);
               rsp_word_in.is_new   = 1'b0;
               rsp_word_in.overflow = 1'b0;
               state_in             = ST_IDLE;
            end else if (probe_ff == vdi_pkg::PROBE_LAST) begin
               // every bucket taken, none matches
               rsp_valid_in         = 1'b1;
               rsp_word_in.vert_idx = '0;
               rsp_word_in.is_new   = 1'b0;
               rsp_word_in.overflow = 1'b1;
               state_in             = ST_IDLE;
            end else begin
               slot_in  = slot_ff + vdi_pkg::BKT_W'(1);
               probe_in = probe_ff + vdi_pkg::BKT_W'(1);
               state_in = ST_BRD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      slot_ff     <= slot_in;
      probe_ff    <= probe_in;
      idx_ff      <= idx_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

### hw/rtl/vdi_checker.sv
module vdi_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input vdi_pkg::rsp_word_type rsp_word
);

   // bucket clearing after reset
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> busy)
      else $error("not busy right after reset");

   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("result shown while still busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_word.is_new && rsp_word.overflow))
      else $error("new and overflow together");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.overflow) |-> (rsp_word.vert_idx == '0))
      else $error("overflow with nonzero index");

endmodule

bind vertex_dedup_indexer_unit vdi_checker u_vdi_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_word  (rsp_word)
);

### bench/vertex_dedup_indexer_unit_tb.sv
`timescale 1ns / 1ps
module vertex_dedup_indexer_unit_tb;
   import vdi_pkg::*;

   typedef struct {
      req_word_type word;
      int           idle_pct;
      bit           wait_drain;
   } vertex_job_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           start = 1'b0;
   logic           busy;
   req_word_type   req_word = '0;
   logic           rsp_valid;
   rsp_word_type   rsp_word;

   vertex_job_type job_queue[$];
   rsp_word_type   index_queue[$];
   int unsigned    vertex_id [logic [KEY_W-1:0]];
   int unsigned    vertex_total = 0;
   req_word_type   issued_pos[$];
   bit             issued_set [logic [KEY_W-1:0]];
   int             fail_count = 0;

   vertex_dedup_indexer_unit uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #50_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic rsp_word_type lookup_vertex(req_word_type pos);
      rsp_word_type     r;
      logic [KEY_W-1:0] key;
      key = pos;
      r = '0;
      if (vertex_id.exists(key)) begin
         r.vert_idx = OUT_IDX_W'(vertex_id[key]);
      end else if (vertex_total >= MAX_UNIQUE) begin
         r.overflow = 1'b1;
      end else begin
         vertex_id[key] = vertex_total;
         r.vert_idx = OUT_IDX_W'(vertex_total);
         r.is_new = 1'b1;
         vertex_total++;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
      fail_count++;
   endtask

   task automatic add_job(req_word_type pos, int idle_pct, bit wait_drain);
      vertex_job_type   job;
      logic [KEY_W-1:0] key;
      key = pos;
      job.word = pos;
      job.idle_pct = idle_pct;
      job.wait_drain = wait_drain;
      job_queue.insert(job_queue.size(), job);
      if (!issued_set.exists(key)) begin
         issued_set[key] = 1'b1;
         issued_pos.insert(issued_pos.size(), pos);
      end
   endtask

   function automatic req_word_type random_pos();
      req_word_type p;
      p.pos_x = $urandom();
      p.pos_y = $urandom();
      p.pos_z = $urandom();
      return p;
   endfunction

   function automatic logic [POS_W-1:0] odd_float();
      case ($urandom_range(7))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;
         2: return 32'h7f80_0000;
         3: return 32'hff80_0000;
         4: return 32'h7fc0_0000;
         5: return 32'hffff_ffff;
         6: return 32'h0000_0001;
         default: return 32'h7f7f_ffff;
      endcase
   endfunction

   function automatic req_word_type mixed_pos();
      req_word_type p;
      int           roll;
      int           b;
      roll = $urandom_range(99);
      if (issued_pos.size() == 0 || (roll >= 35 && roll < 70)) begin
         p = random_pos();
      end else if (roll >= 95) begin
         p.pos_x = odd_float();
         p.pos_y = odd_float();
         p.pos_z = odd_float();
      end else begin
         p = issued_pos[$urandom_range(issued_pos.size() - 1)];
         if (roll >= 85) begin
            // two bits 13 apart, which fold onto the same bucket as the original
            b = $urandom_range(18);
            p.pos_x = p.pos_x ^ (32'h1 << b) ^ (32'h1 << (b + 13));
         end else if (roll >= 70) begin
            b = $urandom_range(31);
            case ($urandom_range(2))
               0: p.pos_x[b] = ~p.pos_x[b];
               1: p.pos_y[b] = ~p.pos_y[b];
               default: p.pos_z[b] = ~p.pos_z[b];
            endcase
         end
      end
      return p;
   endfunction

   initial begin : stimulus
      int idle;
      add_job({32'h0, 32'h0, 32'h0}, 0, 1'b0);
      add_job({32'h0, 32'h0, 32'h0}, 0, 1'b0);
      // signed zeros are distinct keys
      add_job({32'h8000_0000, 32'h0, 32'h0}, 0, 1'b0);
      add_job({32'h0, 32'h8000_0000, 32'h0}, 0, 1'b0);
      add_job({32'h0, 32'h0, 32'h8000_0000}, 0, 1'b0);
      add_job({32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 0, 1'b0);
      // nan matches the same bit pattern
      add_job({32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff}, 0, 1'b0);
      add_job({32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff}, 0, 1'b0);
      add_job({32'h7fc0_0000, 32'h7fc0_0000, 32'h7fc0_0000}, 0, 1'b0);
      add_job({32'h7fc0_0000, 32'h7fc0_0000, 32'h7fc0_0000}, 0, 1'b0);
      add_job({32'h7f80_0000, 32'hff80_0000, 32'h7f7f_ffff}, 0, 1'b0);
      add_job({32'h0000_0001, 32'h0, 32'h0}, 0, 1'b0);
      add_job({32'h0, 32'h0, 32'h0000_0001}, 0, 1'b0);
      add_job({32'h8000_0000, 32'h0, 32'h0}, 0, 1'b0);
      add_job({32'h7f80_0000, 32'hff80_0000, 32'h7f7f_ffff}, 0, 1'b0);
      add_job({32'h0, 32'h0, 32'h0}, 0, 1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         idle = (phase == 1) ? 47 : (phase == 3) ? 24 : 0;
         for (int n = 0; n < 150; n++) begin
            add_job(mixed_pos(), idle, n == 0);
         end
      end
   end

   always @(posedge clock) begin : feed
      bit go;
      go = 1'b0;
      if (job_queue.size() != 0) begin
         go = $urandom_range(99) >= job_queue[0].idle_pct;
         if (job_queue[0].wait_drain && (start || index_queue.size() != 0)) begin
            go = 1'b0;
         end
      end
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (go) begin
            req_word <= job_queue[0].word;
            start <= 1'b1;
            void'(job_queue.pop_front());
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : watch
      rsp_word_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (index_queue.size() == 0) begin
               report_mismatch("word with nothing pending, index", 32'(rsp_word.vert_idx), 0);
            end else begin
               want = index_queue.pop_front();
               if (rsp_word.vert_idx !== want.vert_idx)
                  report_mismatch("vert_idx", 32'(rsp_word.vert_idx), 32'(want.vert_idx));
               if (rsp_word.is_new !== want.is_new)
                  report_mismatch("is_new", 32'(rsp_word.is_new), 32'(want.is_new));
               if (rsp_word.overflow !== want.overflow)
                  report_mismatch("overflow", 32'(rsp_word.overflow), 32'(want.overflow));
            end
         end
         if (start && !busy) begin
            index_queue.insert(index_queue.size(), lookup_vertex(req_word));
         end
      end
   end

   initial begin : finish_run
      repeat (12) @(posedge clock);
      while (job_queue.size() != 0 || start || index_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (64) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
